// ===== rtl/nrc_pkg.sv =====
package nrc_pkg;

    localparam int MAX_KERNEL = 5;
    localparam int KSLOTS     = MAX_KERNEL * MAX_KERNEL;
    localparam int KIDX_W     = $clog2(KSLOTS);
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RING_ROWS  = MAX_KERNEL + 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SLOT_W     = $clog2(RING_ROWS);
    localparam int DIM_W      = 11;
    localparam int KDIM_W     = 3;
    localparam int COEF_BITS  = 16;
    localparam int PIX_W      = 24;
    localparam int CH         = 3;
    localparam int PROD_W     = COEF_BITS + 9;
    localparam int ACC_W      = 29;
    localparam int SUM_W      = 21;
    localparam int CUR_W      = 21;
    localparam int QW         = 8;
    localparam int DIV_W      = 28;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } nrc_op_t;

    typedef enum logic [1:0] {
        REG_IMG_WIDTH  = 2'd0,
        REG_IMG_HEIGHT = 2'd1,
        REG_KER_WIDTH  = 2'd2,
        REG_KER_HEIGHT = 2'd3
    } nrc_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAPS,
        S_DRAIN,
        S_PREP,
        S_DIVW
    } nrc_state_t;

    // one slot of the restoring divide chain, three channels share the divisor
    typedef struct packed {
        logic                     vld;
        logic [DIV_W-1:0]         dsh;
        logic [CH-1:0][DIV_W-1:0] rem;
        logic [CH-1:0][QW-1:0]    quo;
    } nrc_div_t;

endpackage

// ===== rtl/normalized_rgb_convolution.sv =====
// Normalized RGB convolution over a raster pixel stream. Each input item is a
// coefficient load, a pixel, a flush tick or an ignored no-op (s_tuser). An
// item that produces a pixel holds s_tready low until its result is registered:
// the window is read one tap per cycle from the single read port of the line
// memory, then the three channel sums go through an eight-cell restoring divide
// chain, one quotient bit per cell. Configuration must be written over the
// register port while the block is idle; the block does not enforce it. The
// line memory needs no clearing pass and is usable right after reset.
module normalized_rgb_convolution
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // coef_index, coef_value, red_in, green_in, blue_in, 3 zero bits
    input  logic [47:0] s_tdata,
    // opcode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red_out, green_out, blue_out, out_column, out_row, 4 zero bits
    output logic [47:0] m_tdata,
    // zero_sum
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW  = nrc_pkg::COL_W;
    localparam int DW  = nrc_pkg::DIM_W;
    localparam int SW  = nrc_pkg::SLOT_W;
    localparam int AW  = nrc_pkg::ACC_W;
    localparam int SUW = nrc_pkg::SUM_W;
    localparam int DIV_W_L = nrc_pkg::DIV_W;

    // configuration
    logic [DW-1:0]                   img_w_reg;
    logic [DW-1:0]                   img_h_reg;
    logic [nrc_pkg::KDIM_W-1:0]      ker_w_reg;
    logic [nrc_pkg::KDIM_W-1:0]      ker_h_reg;
    logic                            cfg_wr;
    nrc_pkg::nrc_reg_t               cfg_sel;

    logic [DW-1:0]                   w;
    logic [DW-1:0]                   h;
    logic [nrc_pkg::KDIM_W-1:0]      kw;
    logic [nrc_pkg::KDIM_W-1:0]      kh;
    logic [1:0]                      kw_half;
    logic [1:0]                      kh_half;
    logic [1:0]                      kh_low;
    logic [nrc_pkg::KDIM_W-1:0]      right;
    logic [nrc_pkg::CUR_W-1:0]       delay;

    // kernel and position state
    logic signed [nrc_pkg::COEF_BITS-1:0] kernel_reg [0:nrc_pkg::KSLOTS-1];
    logic [CW-1:0]                   in_col_reg;
    logic [DW-1:0]                   in_row_reg;
    logic [SW-1:0]                   in_slot_reg;
    logic [nrc_pkg::CUR_W-1:0]       cur;
    logic [CW-1:0]                   emit_col_reg;
    logic [CW-1:0]                   emit_row_reg;
    logic [SW-1:0]                   emit_slot_reg;

    // item decode
    nrc_pkg::nrc_op_t                op;
    logic                            accept;
    logic                            step;
    logic                            wr_pix;
    logic                            result;
    logic                            last_now;
    logic                            in_wrap;
    logic                            emit_wrap;
    logic [4:0]                      ld_idx;

    // tap sequencing
    nrc_pkg::nrc_state_t             state_reg;
    nrc_pkg::nrc_state_t             state_next;
    logic                            tap_en;
    logic                            launch;
    logic                            last_tap;
    logic [CW-1:0]                   r_reg;
    logic [CW-1:0]                   c_reg;
    logic [SW-1:0]                   rs_reg;
    logic                            last_reg;
    logic [nrc_pkg::KDIM_W-1:0]      kr_reg;
    logic [nrc_pkg::KDIM_W-1:0]      kc_reg;
    logic [nrc_pkg::KIDX_W-1:0]      kidx_reg;

    logic signed [11:0]              tap_row;
    logic signed [11:0]              tap_col;
    logic                            tap_out;
    logic [3:0]                      slot_sum;
    logic [SW-1:0]                   tap_slot;
    logic [SW+CW-1:0]                rd_addr;
    logic [SW+CW-1:0]                wr_addr;

    logic [nrc_pkg::PIX_W-1:0]       line_mem [0:nrc_pkg::RING_ROWS*nrc_pkg::MAX_WIDTH-1];
    logic [nrc_pkg::PIX_W-1:0]       px_reg;
    logic signed [nrc_pkg::COEF_BITS-1:0] coef1_reg;
    logic signed [nrc_pkg::COEF_BITS-1:0] coef2_reg;
    logic                            vld1_reg;
    logic                            vld2_reg;
    logic signed [nrc_pkg::PROD_W-1:0] prod_reg [0:nrc_pkg::CH-1];
    logic signed [AW-1:0]            acc_reg [0:nrc_pkg::CH-1];
    logic signed [SUW-1:0]           sum_reg;

    // divide setup
    logic                            sum_zero;
    logic [SUW-1:0]                  sum_neg;
    logic [19:0]                     div_abs;
    logic                            div_neg;
    logic [AW-1:0]                   acc_neg [0:nrc_pkg::CH-1];
    logic [DIV_W_L-1:0]              acc_abs [0:nrc_pkg::CH-1];
    logic [nrc_pkg::CH-1:0]          force0_reg;
    logic [nrc_pkg::CH-1:0]          sat_reg;
    logic                            zero_reg;
    nrc_pkg::nrc_div_t               div_in_reg;
    nrc_pkg::nrc_div_t               div_out;

    // result register
    logic                            m_tvalid_reg;
    logic [nrc_pkg::CH-1:0][7:0]     rgb_reg;
    logic [CW-1:0]                   out_col_reg;
    logic [CW-1:0]                   out_row_reg;
    logic                            out_last_reg;
    logic                            out_zero_reg;

    // register port
    assign pready  = 1'b1;
    assign cfg_sel = nrc_pkg::nrc_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_comb
    begin
        unique case (cfg_sel)
            nrc_pkg::REG_IMG_WIDTH:  prdata = {21'd0, img_w_reg};
            nrc_pkg::REG_IMG_HEIGHT: prdata = {21'd0, img_h_reg};
            nrc_pkg::REG_KER_WIDTH:  prdata = {29'd0, ker_w_reg};
            nrc_pkg::REG_KER_HEIGHT: prdata = {29'd0, ker_h_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= DW'(256);
            img_h_reg <= DW'(256);
            ker_w_reg <= 3'd3;
            ker_h_reg <= 3'd3;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                nrc_pkg::REG_IMG_WIDTH:  img_w_reg <= pwdata[DW-1:0];
                nrc_pkg::REG_IMG_HEIGHT: img_h_reg <= pwdata[DW-1:0];
                nrc_pkg::REG_KER_WIDTH:  ker_w_reg <= pwdata[2:0];
                nrc_pkg::REG_KER_HEIGHT: ker_h_reg <= pwdata[2:0];
                default:                 ;
            endcase
        end
    end

    // sizes in use
    always_comb
    begin
        if (img_w_reg == '0)
            w = DW'(1);
        else if (img_w_reg > DW'(nrc_pkg::MAX_WIDTH))
            w = DW'(nrc_pkg::MAX_WIDTH);
        else
            w = img_w_reg;

        if (img_h_reg == '0)
            h = DW'(1);
        else if (img_h_reg > DW'(nrc_pkg::MAX_HEIGHT))
            h = DW'(nrc_pkg::MAX_HEIGHT);
        else
            h = img_h_reg;

        if (ker_w_reg == '0)
            kw = 3'd1;
        else if (ker_w_reg > 3'(nrc_pkg::MAX_KERNEL))
            kw = 3'(nrc_pkg::MAX_KERNEL);
        else
            kw = ker_w_reg;

        if (ker_h_reg == '0)
            kh = 3'd1;
        else if (ker_h_reg > 3'(nrc_pkg::MAX_KERNEL))
            kh = 3'(nrc_pkg::MAX_KERNEL);
        else
            kh = ker_h_reg;

        kw_half = kw[2:1];
        kh_half = kh[2:1];
        kh_low  = 2'(kh - 3'd1 - {1'b0, kh_half});
        right   = kw - 3'd1 - {1'b0, kw_half};
        if ({8'd0, right} > w - DW'(1))
            right = (w - DW'(1)) < DW'(3) ? 3'((w - DW'(1))) : right;

        // input items held back before the first result: whole lines plus the right margin
        case (kh_low)
            2'd1:    delay = nrc_pkg::CUR_W'(w);
            2'd2:    delay = nrc_pkg::CUR_W'({w, 1'b0});
            default: delay = '0;
        endcase
        delay = delay + nrc_pkg::CUR_W'(right);
    end

    // linear input index, follows the width in use
    assign cur = nrc_pkg::CUR_W'(in_row_reg) * nrc_pkg::CUR_W'(w)
               + nrc_pkg::CUR_W'(in_col_reg);

    // item decode
    assign op       = nrc_pkg::nrc_op_t'(s_tuser);
    assign accept   = s_tvalid & s_tready;
    assign ld_idx   = s_tdata[4:0];
    assign last_now = ({1'b0, emit_row_reg} >= h - DW'(1))
                    && ({1'b0, emit_col_reg} >= w - DW'(1));
    assign in_wrap  = ({1'b0, in_col_reg} + DW'(1)) >= w;
    assign emit_wrap = ({1'b0, emit_col_reg} + DW'(1)) >= w;

    always_comb
    begin
        step   = 1'b0;
        wr_pix = 1'b0;
        if (accept)
        begin
            unique case (op)
                nrc_pkg::OP_PIXEL:
                begin
                    step   = 1'b1;
                    wr_pix = in_row_reg < h;
                end
                nrc_pkg::OP_FLUSH:
                begin
                    step = in_row_reg >= h;
                end
                default:
                begin
                    step   = 1'b0;
                    wr_pix = 1'b0;
                end
            endcase
        end
        result = step && (cur >= delay);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < nrc_pkg::KSLOTS; i++)
                kernel_reg[i] <= '0;
        end
        else if (accept && op == nrc_pkg::OP_LOAD && ld_idx < 5'(nrc_pkg::KSLOTS))
        begin
            kernel_reg[ld_idx] <= s_tdata[20:5];
        end
    end

    // raster position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            emit_col_reg  <= '0;
            emit_row_reg  <= '0;
            emit_slot_reg <= '0;
        end
        else if (step)
        begin
            if (result && last_now)
            begin
                in_col_reg    <= '0;
                in_row_reg    <= '0;
                in_slot_reg   <= '0;
                emit_col_reg  <= '0;
                emit_row_reg  <= '0;
                emit_slot_reg <= '0;
            end
            else
            begin
                if (in_wrap)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + DW'(1);
                    in_slot_reg <= (in_slot_reg == SW'(nrc_pkg::RING_ROWS - 1))
                                 ? '0 : in_slot_reg + SW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
                if (result)
                begin
                    if (emit_wrap)
                    begin
                        emit_col_reg  <= '0;
                        emit_row_reg  <= emit_row_reg + CW'(1);
                        emit_slot_reg <= (emit_slot_reg == SW'(nrc_pkg::RING_ROWS - 1))
                                       ? '0 : emit_slot_reg + SW'(1);
                    end
                    else
                    begin
                        emit_col_reg <= emit_col_reg + CW'(1);
                    end
                end
            end
        end
    end

    // sequencer
    assign last_tap = (kr_reg == kh - 3'd1) && (kc_reg == kw - 3'd1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nrc_pkg::S_IDLE:  if (result) state_next = nrc_pkg::S_TAPS;
            nrc_pkg::S_TAPS:  if (last_tap) state_next = nrc_pkg::S_DRAIN;
            nrc_pkg::S_DRAIN: if (!vld1_reg && !vld2_reg) state_next = nrc_pkg::S_PREP;
            nrc_pkg::S_PREP:  if (!m_tvalid_reg) state_next = nrc_pkg::S_DIVW;
            nrc_pkg::S_DIVW:  if (div_out.vld) state_next = nrc_pkg::S_IDLE;
            default:          state_next = nrc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        tap_en   = 1'b0;
        launch   = 1'b0;
        unique case (state_reg)
            nrc_pkg::S_IDLE: s_tready = 1'b1;
            nrc_pkg::S_TAPS: tap_en   = 1'b1;
            nrc_pkg::S_PREP: launch   = !m_tvalid_reg;
            default:
            begin
                s_tready = 1'b0;
                tap_en   = 1'b0;
                launch   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nrc_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kr_reg   <= '0;
            kc_reg   <= '0;
            kidx_reg <= '0;
        end
        else if (result)
        begin
            kr_reg   <= '0;
            kc_reg   <= '0;
            kidx_reg <= '0;
        end
        else if (tap_en && !last_tap)
        begin
            kidx_reg <= kidx_reg + nrc_pkg::KIDX_W'(1);
            if (kc_reg == kw - 3'd1)
            begin
                kc_reg <= '0;
                kr_reg <= kr_reg + 3'd1;
            end
            else
            begin
                kc_reg <= kc_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result)
        begin
            r_reg    <= emit_row_reg;
            c_reg    <= emit_col_reg;
            rs_reg   <= emit_slot_reg;
            last_reg <= last_now;
        end
    end

    // tap address, a tap outside the image falls back to the center pixel
    always_comb
    begin
        tap_row  = signed'({2'b00, r_reg}) + signed'({9'd0, kr_reg})
                 - signed'({10'd0, kh_half});
        tap_col  = signed'({2'b00, c_reg}) + signed'({9'd0, kc_reg})
                 - signed'({10'd0, kw_half});
        tap_out  = tap_row[11] || (tap_row >= signed'({1'b0, h}))
                 || tap_col[11] || (tap_col >= signed'({1'b0, w}));
        slot_sum = {1'b0, rs_reg} + {1'b0, kr_reg} + 4'(nrc_pkg::RING_ROWS)
                 - {2'b00, kh_half};
        if (slot_sum >= 4'(2 * nrc_pkg::RING_ROWS))
            tap_slot = SW'(slot_sum - 4'(2 * nrc_pkg::RING_ROWS));
        else if (slot_sum >= 4'(nrc_pkg::RING_ROWS))
            tap_slot = SW'(slot_sum - 4'(nrc_pkg::RING_ROWS));
        else
            tap_slot = SW'(slot_sum);
        if (tap_out)
            rd_addr = {rs_reg, c_reg};
        else
            rd_addr = {tap_slot, tap_col[CW-1:0]};
    end

    assign wr_addr = {in_slot_reg, in_col_reg};

    always_ff @(posedge clk)
    begin
        if (wr_pix)
            line_mem[wr_addr] <= {s_tdata[28:21], s_tdata[36:29], s_tdata[44:37]};
        px_reg <= line_mem[rd_addr];
    end

    // multiply and accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= tap_en;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        coef1_reg <= kernel_reg[kidx_reg];
        coef2_reg <= coef1_reg;
        for (int i = 0; i < nrc_pkg::CH; i++)
            prod_reg[i] <= signed'({1'b0, px_reg[23-8*i -: 8]}) * coef1_reg;
        if (result)
        begin
            for (int i = 0; i < nrc_pkg::CH; i++)
                acc_reg[i] <= '0;
            sum_reg <= '0;
        end
        else if (vld2_reg)
        begin
            for (int i = 0; i < nrc_pkg::CH; i++)
                acc_reg[i] <= acc_reg[i] + AW'(prod_reg[i]);
            sum_reg <= sum_reg + SUW'(coef2_reg);
        end
    end

    // signs and magnitudes for the divide chain
    always_comb
    begin
        sum_zero = (sum_reg == '0);
        sum_neg  = -sum_reg;
        div_neg  = !sum_zero && sum_reg[SUW-1];
        if (sum_zero)
            div_abs = 20'd256;
        else if (sum_reg[SUW-1])
            div_abs = sum_neg[19:0];
        else
            div_abs = sum_reg[19:0];
        for (int i = 0; i < nrc_pkg::CH; i++)
        begin
            acc_neg[i] = -acc_reg[i];
            acc_abs[i] = acc_reg[i][AW-1] ? acc_neg[i][DIV_W_L-1:0]
                                          : acc_reg[i][DIV_W_L-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_in_reg <= '0;
        end
        else
        begin
            div_in_reg.vld <= launch;
            if (launch)
            begin
                div_in_reg.dsh <= {1'b0, div_abs, 7'd0};
                for (int i = 0; i < nrc_pkg::CH; i++)
                begin
                    div_in_reg.rem[i] <= acc_abs[i];
                    div_in_reg.quo[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            for (int i = 0; i < nrc_pkg::CH; i++)
            begin
                force0_reg[i] <= acc_reg[i][AW-1] ^ div_neg;
                sat_reg[i]    <= acc_abs[i] >= {div_abs, 8'd0};
            end
            zero_reg <= sum_zero;
        end
    end

    nrc_divider u_divider
    (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (div_in_reg),
        .dout (div_out)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (div_out.vld)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (div_out.vld)
        begin
            for (int i = 0; i < nrc_pkg::CH; i++)
            begin
                if (force0_reg[i])
                    rgb_reg[i] <= 8'd0;
                else if (sat_reg[i])
                    rgb_reg[i] <= 8'd255;
                else
                    rgb_reg[i] <= div_out.quo[i];
            end
            out_col_reg  <= c_reg;
            out_row_reg  <= r_reg;
            out_last_reg <= last_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_row_reg, out_col_reg, rgb_reg[2], rgb_reg[1], rgb_reg[0]};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_zero_reg;

`ifndef SYNTHESIS
    a_div_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_out.vld |-> (state_reg == nrc_pkg::S_DIVW && !m_tvalid_reg))
        else $error("divide chain finished while result register busy");

    a_ring_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (in_slot_reg < SW'(nrc_pkg::RING_ROWS)) && (emit_slot_reg < SW'(nrc_pkg::RING_ROWS)))
        else $error("line ring slot out of range");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nrc_pkg::S_IDLE) |-> (!vld1_reg && !vld2_reg && !div_in_reg.vld))
        else $error("tap pipeline busy while accepting items");

    a_tap_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nrc_pkg::S_TAPS) |-> (kidx_reg < nrc_pkg::KIDX_W'(nrc_pkg::KSLOTS)))
        else $error("kernel index past the store");
`endif

endmodule

// ===== rtl/nrc_div_cell.sv =====
module nrc_div_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  nrc_pkg::nrc_div_t din,
    output nrc_pkg::nrc_div_t dout
);

    nrc_pkg::nrc_div_t dout_reg;
    nrc_pkg::nrc_div_t dout_next;

    always_comb
    begin
        dout_next     = din;
        dout_next.dsh = din.dsh >> 1;
        for (int i = 0; i < nrc_pkg::CH; i++)
        begin
            if (din.rem[i] >= din.dsh)
            begin
                dout_next.rem[i] = din.rem[i] - din.dsh;
                dout_next.quo[i] = {din.quo[i][nrc_pkg::QW-2:0], 1'b1};
            end
            else
            begin
                dout_next.quo[i] = {din.quo[i][nrc_pkg::QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ===== rtl/nrc_divider.sv =====
module nrc_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  nrc_pkg::nrc_div_t din,
    output nrc_pkg::nrc_div_t dout
);

    // one quotient bit per cell, msb first
    nrc_pkg::nrc_div_t chain [0:nrc_pkg::QW];

    assign chain[0] = din;

    for (genvar k = 0; k < nrc_pkg::QW; k++)
    begin : g_cell
        nrc_div_cell u_cell
        (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (chain[k]),
            .dout (chain[k+1])
        );
    end

    assign dout = chain[nrc_pkg::QW];

endmodule

// ===== sim/nrc_checker.sv =====
module nrc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] col;
        logic [9:0] row;
        logic       last;
        logic       zero;
    } pix_result_t;

    pix_result_t filtered_q[$];

    logic [nrc_pkg::DIM_W-1:0]  img_w_reg, img_h_reg;
    logic [nrc_pkg::KDIM_W-1:0] ker_w_reg, ker_h_reg;
    logic signed [nrc_pkg::COEF_BITS-1:0] coef_mem [nrc_pkg::KSLOTS];
    logic [nrc_pkg::PIX_W-1:0]  row_mem [nrc_pkg::RING_ROWS*nrc_pkg::MAX_WIDTH];
    int in_col, in_row, out_col, out_row;

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [nrc_pkg::PIX_W-1:0] fetch(int row, int col);
        return row_mem[(row % nrc_pkg::RING_ROWS) * nrc_pkg::MAX_WIDTH + col];
    endfunction

    function automatic logic [7:0] sat_div(longint acc, longint dv);
        longint q;
        q = acc / dv;
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    // advances the filter state by one item, returns 1 when a pixel leaves
    function automatic bit filter_step(nrc_pkg::nrc_op_t op, logic [47:0] d,
                                       output pix_result_t res);
        int w, h, kw, kh, cur, right, delay, tr, tc;
        longint acc [3];
        longint sum, coef, dv;
        logic [nrc_pkg::PIX_W-1:0] px;
        w = clampi(int'(img_w_reg), 1, nrc_pkg::MAX_WIDTH);
        h = clampi(int'(img_h_reg), 1, nrc_pkg::MAX_HEIGHT);
        kw = clampi(int'(ker_w_reg), 1, nrc_pkg::MAX_KERNEL);
        kh = clampi(int'(ker_h_reg), 1, nrc_pkg::MAX_KERNEL);
        res = '0;
        if (op == nrc_pkg::OP_LOAD)
        begin
            if (d[4:0] < nrc_pkg::KSLOTS) coef_mem[d[4:0]] = d[20:5];
            return 0;
        end
        if (op == nrc_pkg::OP_NONE) return 0;
        if (in_row < h)
        begin
            if (op == nrc_pkg::OP_FLUSH) return 0;
            row_mem[(in_row % nrc_pkg::RING_ROWS) * nrc_pkg::MAX_WIDTH + in_col] =
                {d[28:21], d[36:29], d[44:37]};
        end
        cur = in_row * w + in_col;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        right = kw - 1 - kw / 2;
        if (right > w - 1) right = w - 1;
        delay = (kh - 1 - kh / 2) * w + right;
        if (cur < delay) return 0;
        acc = '{0, 0, 0};
        sum = 0;
        for (int kr = 0; kr < kh; kr++)
        begin
            for (int kc = 0; kc < kw; kc++)
            begin
                coef = coef_mem[kr * kw + kc];
                tr = out_row + kr - kh / 2;
                tc = out_col + kc - kw / 2;
                if (tr < 0 || tr >= h || tc < 0 || tc >= w) px = fetch(out_row, out_col);
                else px = fetch(tr, tc);
                sum += coef;
                acc[0] += longint'(px[23:16]) * coef;
                acc[1] += longint'(px[15:8]) * coef;
                acc[2] += longint'(px[7:0]) * coef;
            end
        end
        res.zero = (sum == 0);
        dv = res.zero ? 256 : sum;
        res.red = sat_div(acc[0], dv);
        res.green = sat_div(acc[1], dv);
        res.blue = sat_div(acc[2], dv);
        res.col = out_col[9:0];
        res.row = out_row[9:0];
        res.last = (out_row >= h - 1) && (out_col >= w - 1);
        if (res.last)
        begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pix_result_t res, got, want;
        if (!rst_n)
        begin
            img_w_reg = 11'd256;
            img_h_reg = 11'd256;
            ker_w_reg = 3'd3;
            ker_h_reg = 3'd3;
            foreach (coef_mem[i]) coef_mem[i] = '0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            filtered_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (nrc_pkg::nrc_reg_t'(paddr[3:2]))
                    nrc_pkg::REG_IMG_WIDTH:  img_w_reg = pwdata[nrc_pkg::DIM_W-1:0];
                    nrc_pkg::REG_IMG_HEIGHT: img_h_reg = pwdata[nrc_pkg::DIM_W-1:0];
                    nrc_pkg::REG_KER_WIDTH:  ker_w_reg = pwdata[nrc_pkg::KDIM_W-1:0];
                    nrc_pkg::REG_KER_HEIGHT: ker_h_reg = pwdata[nrc_pkg::KDIM_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[33:24],
                       m_tdata[43:34], m_tlast, m_tuser};
                if (filtered_q.size() == 0)
                begin
                    errors++;
                    $display("%t: unexpected item, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%t: mismatch, expected %h, actual %h (r g b col row last zero)",
                                 $time, want, got);
                    end
                end
            end
            if (s_tvalid && s_tready)
                if (filter_step(nrc_pkg::nrc_op_t'(s_tuser), s_tdata, res))
                    filtered_q.push_back(res);
            pending = filtered_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk, rst_n;
    logic        s_tvalid, s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid, m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser, m_tlast;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          errors, pending;
    int          hold_req, hold_done, quiet, sent;
    bit          tx_idle;

    normalized_rgb_convolution DUT (.*);

    nrc_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog over all three channels
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= 5000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result receiver with random stalls and one long hold-off on request
    initial
    begin
        int gap;
        bit rx_idle;
        m_tready = 0;
        hold_done = 0;
        rx_idle = 1;
        @(posedge rst_n);
        forever
        begin
            if (hold_req != hold_done)
            begin
                m_tready <= 0;
                repeat (400) @(posedge clk);
                hold_done++;
            end
            if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
            gap = rx_idle ? $urandom_range(0, 18) : 0;
            if (gap > 0)
            begin
                m_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_item(nrc_pkg::nrc_op_t op, logic [4:0] idx, logic [15:0] coef,
                             logic [23:0] rgb);
        int gap;
        gap = tx_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {3'b000, rgb[7:0], rgb[15:8], rgb[23:16], coef, idx};
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    task automatic reg_write(nrc_pkg::nrc_reg_t r, logic [31:0] v);
        s_tvalid <= 0;
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
    endtask

    // waits away from the sampling edge until every expected result has come
    task automatic drain_wait();
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 0;
        drain_wait();
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 24'h000000;
            1: return 24'hffffff;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // one image: size registers, kernel load, pixels with noise, then drain
    task automatic run_image(int wr, int hr, int kwr, int khr, int profile, bit hold);
        int w, h, kw, kh, right, drain, center;
        logic [15:0] c;
        w = clampi(wr, 1, nrc_pkg::MAX_WIDTH);
        h = clampi(hr, 1, nrc_pkg::MAX_HEIGHT);
        kw = clampi(kwr, 1, nrc_pkg::MAX_KERNEL);
        kh = clampi(khr, 1, nrc_pkg::MAX_KERNEL);
        settle();
        reg_write(nrc_pkg::REG_IMG_WIDTH, wr);
        reg_write(nrc_pkg::REG_IMG_HEIGHT, hr);
        reg_write(nrc_pkg::REG_KER_WIDTH, kwr);
        reg_write(nrc_pkg::REG_KER_HEIGHT, khr);
        tx_idle = ($urandom_range(0, 3) != 0);
        center = (kh / 2) * kw + kw / 2;
        for (int i = 0; i < nrc_pkg::KSLOTS; i++)
        begin
            case (profile)
                0: c = (i == center) ? 16'd256 : 16'd0;
                1: c = 16'($urandom_range(0, 512));
                2: c = 16'($urandom());
                default: c = (i % 2) ? 16'd300 : -16'sd300; // zero total in pairs
            endcase
            if (profile == 3 && i == nrc_pkg::KSLOTS - 1) c = '0;
            send_item(nrc_pkg::OP_LOAD, 5'(i), c, 24'($urandom()));
        end
        if (profile == 3 && (kw * kh) % 2)
            send_item(nrc_pkg::OP_LOAD, 5'(center), 16'd0, 24'($urandom()));
        // ignored items: out of range load, unknown opcode, early flush
        send_item(nrc_pkg::OP_LOAD, 5'($urandom_range(25, 31)), 16'($urandom()),
                  24'($urandom()));
        send_item(nrc_pkg::OP_NONE, 5'($urandom()), 16'($urandom()), 24'($urandom()));
        send_item(nrc_pkg::OP_FLUSH, 5'($urandom()), 16'($urandom()), 24'($urandom()));
        if (hold) hold_req++;
        for (int n = 0; n < w * h; n++)
        begin
            case ($urandom_range(0, 40))
                0: send_item(nrc_pkg::OP_FLUSH, 5'($urandom()), 16'($urandom()),
                             24'($urandom()));
                1: send_item(nrc_pkg::OP_NONE, 5'($urandom()), 16'($urandom()),
                             24'($urandom()));
                2: if (profile == 1) send_item(nrc_pkg::OP_LOAD, 5'($urandom_range(0, 24)),
                                               16'($urandom_range(0, 512)), 24'($urandom()));
                default: ;
            endcase
            send_item(nrc_pkg::OP_PIXEL, 5'($urandom()), 16'($urandom()), rand_pixel());
        end
        right = kw - 1 - kw / 2;
        if (right > w - 1) right = w - 1;
        drain = (kh - 1 - kh / 2) * w + right;
        // drain with flushes, some as pixels whose data is dropped
        for (int n = 0; n < drain; n++)
            send_item($urandom_range(0, 3) == 0 ? nrc_pkg::OP_PIXEL : nrc_pkg::OP_FLUSH,
                      5'($urandom()), 16'($urandom()), 24'($urandom()));
        send_item(nrc_pkg::OP_FLUSH, 5'($urandom()), 16'($urandom()), 24'($urandom()));
        send_item(nrc_pkg::OP_FLUSH, 5'($urandom()), 16'($urandom()), 24'($urandom()));
        s_tvalid <= 0;
        // sender pauses until the whole image has come out
        drain_wait();
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = nrc_pkg::OP_NONE;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        hold_req = 0;
        sent = 0;
        tx_idle = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extreme coefficients, then simple images
        send_item(nrc_pkg::OP_LOAD, 5'd0, 16'h7fff, 24'h0);
        send_item(nrc_pkg::OP_LOAD, 5'd24, 16'h8000, 24'h0);
        send_item(nrc_pkg::OP_LOAD, 5'd31, 16'h1234, 24'h0);
        run_image(3, 3, 3, 3, 0, 0);
        run_image(2, 2, 5, 5, 2, 0);
        run_image(4, 2, 3, 3, 3, 0);
        run_image(1, 1, 1, 1, 0, 0);
        run_image(12, 6, 7, 0, 1, 1);
        run_image(1, 9, 1, 5, 0, 0);
        run_image(0, 3, 6, 2, 2, 0);
        while (sent < 1200)
        begin
            int w, h;
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            run_image(w, h, $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 3), 0);
        end
        s_tvalid <= 0;
        drain_wait();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nrc_pkg.sv
rtl/nrc_div_cell.sv
rtl/nrc_divider.sv
rtl/normalized_rgb_convolution.sv
sim/nrc_checker.sv
sim/tb.sv
